FILE: design/c1ks_pkg.sv
// shared types, constants and functions for the crypto-1 keystream engine
package c1ks_pkg;

    localparam int HALF_W = 24;
    localparam int WORD_W = 32;
    localparam int KEY_W  = 48;

    localparam logic [HALF_W-1:0] TAPS_ODD   = 24'h29CE5C;
    localparam logic [HALF_W-1:0] TAPS_EVEN  = 24'h870804;
    localparam logic [19:0]       FILT_A     = 20'hf22c0;
    localparam logic [19:0]       FILT_B     = 20'h6c9c0;
    localparam logic [19:0]       FILT_C     = 20'h3c8b0;
    localparam logic [19:0]       FILT_D     = 20'h1e458;
    localparam logic [19:0]       FILT_E     = 20'h0d938;
    localparam logic [31:0]       FILTER_OUT = 32'hEC57E80A;

    typedef enum logic [2:0] {
        OP_LOAD      = 3'd0,
        OP_FWD_WORD  = 3'd1,
        OP_BACK_WORD = 3'd2,
        OP_FWD_BIT   = 3'd3,
        OP_BACK_BIT  = 3'd4
    } opcode_t;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [WORD_W-1:0] data_word;
        logic              feedback_enable;
        logic [HALF_W-1:0] load_odd;
        logic [HALF_W-1:0] load_even;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0] keystream;
        logic [KEY_W-1:0]  key_value;
    } result_t;

    typedef struct packed {
        logic [HALF_W-1:0] odd_half;
        logic [HALF_W-1:0] even_half;
    } lfsr_t;

    function automatic logic nl_filter(input logic [HALF_W-1:0] x);
        logic [19:0] sa;
        logic [19:0] sb;
        logic [19:0] sc;
        logic [19:0] sd;
        logic [19:0] se;
        logic [4:0]  f;
        sa = FILT_A >> x[3:0];
        sb = FILT_B >> x[7:4];
        sc = FILT_C >> x[11:8];
        sd = FILT_D >> x[15:12];
        se = FILT_E >> x[19:16];
        f  = {sa[4], sb[3], sc[2], sd[1], se[0]};
        return FILTER_OUT[f];
    endfunction

    function automatic logic [KEY_W-1:0] key_view(input lfsr_t s);
        logic [KEY_W-1:0] k;
        k = '0;
        for (int i = 0; i < HALF_W; i++)
        begin
            k[2*i+1] = s.odd_half[5'(i) ^ 5'd3];
            k[2*i]   = s.even_half[5'(i) ^ 5'd3];
        end
        return k;
    endfunction

endpackage

FILE: design/crypto1_keystream_engine.sv
// top level: input register, lfsr state, single-pass datapath and result register
// One item enters per clock when the result side is not stalled. An item is held in the input
// register and reaches the result register when it advances, which a result-side stall can hold.
// The 32 unrolled lfsr clocks for a word are combinational, reading the state that the previous
// item left, which is updated at the same edge the result is registered. Load writes the
// halves; opcodes 5 to 7 keep the state and return a zero keystream. The state resets to zero.
module crypto1_keystream_engine
    import c1ks_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    lfsr_t   state_reg;
    lfsr_t   state_next;
    logic    out_valid_reg;
    result_t out_result_reg;
    result_t result_next;
    logic    out_ready;
    logic    advance;

    assign out_ready  = !out_valid_reg || !result_stall;
    assign advance    = in_valid_reg && out_ready;
    assign item_stall = in_valid_reg && !out_ready;

    c1ks_datapath u_datapath (
        .state      (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (!item_stall)
                in_valid_reg <= item_valid;
            if (out_ready)
                out_valid_reg <= in_valid_reg;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
            in_item_reg <= item;
        if (advance)
            out_result_reg <= result_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_result_reg;

endmodule

FILE: design/c1ks_step.sv
// one forward or backward clock of the lfsr with its keystream bit
module c1ks_step
    import c1ks_pkg::*;
(
    input  lfsr_t state_in,
    input  logic  backward,
    input  logic  data_bit,
    input  logic  feedback_enable,
    output lfsr_t state_out,
    output logic  ks_bit
);

    logic [HALF_W-1:0] shifted;
    logic              fwd_ks;
    logic              back_ks;
    logic              fwd_nb;
    logic              back_nb;

    assign fwd_ks  = nl_filter(state_in.odd_half);
    assign back_ks = nl_filter(state_in.even_half);
    assign shifted = {1'b0, state_in.odd_half[HALF_W-1:1]};

    assign fwd_nb = (fwd_ks & feedback_enable) ^ data_bit
                  ^ (^(state_in.odd_half & TAPS_ODD))
                  ^ (^(state_in.even_half & TAPS_EVEN));

    assign back_nb = state_in.odd_half[0]
                   ^ (^(shifted & TAPS_EVEN))
                   ^ (^(state_in.even_half & TAPS_ODD))
                   ^ data_bit ^ (back_ks & feedback_enable);

    always_comb
    begin
        if (backward)
        begin
            ks_bit              = back_ks;
            state_out.odd_half  = state_in.even_half;
            state_out.even_half = {back_nb, state_in.odd_half[HALF_W-1:1]};
        end
        else
        begin
            ks_bit              = fwd_ks;
            state_out.odd_half  = {state_in.even_half[HALF_W-2:0], fwd_nb};
            state_out.even_half = state_in.odd_half;
        end
    end

endmodule

FILE: design/c1ks_datapath.sv
// chain of 32 lfsr clocks and operation select for one item
module c1ks_datapath
    import c1ks_pkg::*;
(
    input  lfsr_t   state,
    input  item_t   item,
    output lfsr_t   state_next,
    output result_t result
);

    lfsr_t             chain [WORD_W+1];
    logic [WORD_W-1:0] ks_bits;
    logic [WORD_W-1:0] ks_word;
    logic              backward;
    logic              bit_mode;

    assign backward = (item.opcode == OP_BACK_WORD) || (item.opcode == OP_BACK_BIT);
    assign bit_mode = (item.opcode == OP_FWD_BIT) || (item.opcode == OP_BACK_BIT);
    assign chain[0] = state;

    for (genvar k = 0; k < WORD_W; k++)
    begin : g_step
        localparam int FWD_POS  = k ^ 24;
        localparam int BACK_POS = (WORD_W - 1 - k) ^ 24;
        logic data_bit;

        if (k == 0)
        begin : g_first
            assign data_bit = bit_mode ? item.data_word[0]
                            : (backward ? item.data_word[BACK_POS]
                                        : item.data_word[FWD_POS]);
        end
        else
        begin : g_rest
            assign data_bit = backward ? item.data_word[BACK_POS]
                                       : item.data_word[FWD_POS];
        end

        c1ks_step u_step (
            .state_in        (chain[k]),
            .backward        (backward),
            .data_bit        (data_bit),
            .feedback_enable (item.feedback_enable),
            .state_out       (chain[k+1]),
            .ks_bit          (ks_bits[k])
        );
    end

    always_comb
    begin
        ks_word = '0;
        for (int k = 0; k < WORD_W; k++)
        begin
            if (backward)
                ks_word[5'(WORD_W - 1 - k) ^ 5'd24] = ks_bits[k];
            else
                ks_word[5'(k) ^ 5'd24] = ks_bits[k];
        end
    end

    always_comb
    begin
        state_next       = state;
        result.keystream = '0;
        case (item.opcode)
            OP_LOAD:
            begin
                state_next.odd_half  = item.load_odd;
                state_next.even_half = item.load_even;
            end
            OP_FWD_WORD, OP_BACK_WORD:
            begin
                state_next       = chain[WORD_W];
                result.keystream = ks_word;
            end
            OP_FWD_BIT, OP_BACK_BIT:
            begin
                state_next       = chain[1];
                result.keystream = {{(WORD_W-1){1'b0}}, ks_bits[0]};
            end
            default:
            begin
                state_next = state;
            end
        endcase
        result.key_value = key_view(state_next);
    end

endmodule
